// ----- design/rvjb_pkg.sv -----
package rvjb_pkg;

  localparam int unsigned RX_COUNT = 4;
  localparam int unsigned RX_IDX_W = (RX_COUNT > 1) ? $clog2(RX_COUNT) : 1;
  localparam int unsigned SLOTS    = 21;
  localparam int unsigned SLOT_W   = 5;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W:0]   MAX_AHEAD = 6'd18;
  localparam logic [9:0]        ERR_RESET = 10'd999;
  localparam int unsigned       CFG_ADDR_W = 4;

  localparam logic [12:0] JITTER_RESET = 13'd100;
  localparam logic [7:0]  PERIOD_RESET = 8'd20;
  localparam logic [15:0] END_RESET    = 16'd1000;

  typedef enum logic [1:0] {
    ACT_HDR   = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_VOICE   = 2'd1,
    KIND_SILENCE = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_JITTER = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_ENDTO  = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  receiver;
    logic [15:0] stream_id;
    logic [31:0] header_tag;
    logic [6:0]  seq;
    logic [7:0]  errors;
    logic [63:0] frame_low;
    logic [31:0] frame_high;
    logic [3:0]  frame_len;
    logic [9:0]  tick_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] frame_low_res;
    logic [31:0] frame_high_res;
    logic [3:0]  source_receiver;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic load;
    logic hdr_open;
    logic hdr_upd;
    logic frame;
    logic init_step;
    logic tick;
    logic push_hdr;
    logic rel_end;
    logic rel_item;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       rx_ok;
    logic       listening;
    logic       end_expire;
    logic       init_done;
    logic       rel_go;
    logic       rel_endonly;
    logic       header_sent;
  } dp_stat_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [9:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {7'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ----- design/receiver_voting_jitter_buffer_core.sv -----
// Voting jitter buffer: start loads one request when busy_o is low; results come out as
// single-cycle strobes on res_valid_o and cannot be held off, the final one of a request
// marked by last. A frame or a header update is applied from S_DEC; a call-opening header
// then walks S_INIT, one slot per cycle, to clear each slot and arm its deadline; a tick may
// go on to S_REL, which sends the header once and then releases expired slots one per cycle,
// and ends in S_FLUSH. Registers sit at byte addresses 0, 4 and 8.
module receiver_voting_jitter_buffer_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  rvjb_pkg::in_item_t                     item_i,
  output logic                                   res_valid_o,
  output rvjb_pkg::res_item_t                    res_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rvjb_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import rvjb_pkg::*;

  logic [12:0] jitter_q;
  logic [7:0]  period_q;
  logic [15:0] end_to_q;
  logic        wr_en;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_q <= JITTER_RESET;
      period_q <= PERIOD_RESET;
      end_to_q <= END_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        CFG_JITTER: jitter_q <= pwdata[12:0];
        CFG_PERIOD: period_q <= pwdata[7:0];
        CFG_ENDTO:  end_to_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_JITTER: prdata = {19'b0, jitter_q};
      CFG_PERIOD: prdata = {24'b0, period_q};
      CFG_ENDTO:  prdata = {16'b0, end_to_q};
      default:    prdata = '0;
    endcase
  end

  rvjb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  rvjb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .jitter_i   (jitter_q),
    .period_i   (period_q),
    .end_to_i   (end_to_q),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// ----- design/rvjb_ctrl.sv -----
module rvjb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rvjb_pkg::dp_stat_t stat_i,
  output rvjb_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);
  import rvjb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEC   = 5'b00010,
    S_INIT  = 5'b00100,
    S_REL   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat_i.action == ACT_HDR && stat_i.rx_ok && stat_i.listening) begin
          cmd_o.hdr_open = 1'b1;
          state_d        = S_INIT;
        end else if (stat_i.action == ACT_HDR && stat_i.rx_ok) begin
          cmd_o.hdr_upd = 1'b1;
          state_d       = S_IDLE;
        end else if (stat_i.action == ACT_FRAME && stat_i.rx_ok) begin
          cmd_o.frame = 1'b1;
          state_d     = S_IDLE;
        end else if (stat_i.action == ACT_TICK) begin
          cmd_o.tick = 1'b1;
          priority if (stat_i.end_expire) state_d = S_FLUSH;
          else if (stat_i.listening)      state_d = S_IDLE;
          else                            state_d = S_REL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.init_done) state_d = S_IDLE;
      end
      S_REL: begin
        // header goes out once, then the same slot is looked at again
        priority if (!stat_i.rel_go) begin
          state_d = S_FLUSH;
        end else if (!stat_i.header_sent) begin
          cmd_o.push_hdr = 1'b1;
        end else if (stat_i.rel_endonly) begin
          cmd_o.rel_end = 1'b1;
          state_d       = S_FLUSH;
        end else begin
          cmd_o.rel_item = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/rvjb_dp.sv -----
module rvjb_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rvjb_pkg::in_item_t  item_i,
  input  rvjb_pkg::dp_cmd_t   cmd_i,
  input  logic [12:0]         jitter_i,
  input  logic [7:0]          period_i,
  input  logic [15:0]         end_to_i,
  output rvjb_pkg::dp_stat_t  stat_o,
  output logic                res_valid_o,
  output rvjb_pkg::res_item_t res_o
);
  import rvjb_pkg::*;

  in_item_t in_q;

  logic                listening_q, header_sent_q, end_run_q;
  logic [31:0]         tag_q;
  logic [SLOT_W-1:0]   exp_q, rel_q, idx_q;
  logic [SLOT_W-1:0]   k_q;
  logic [15:0]         end_el_q, acc_q;
  logic [RX_COUNT-1:0] active_q;
  logic [15:0]         stream_q [RX_COUNT];

  logic [3:0]          length_q   [SLOTS];
  logic [9:0]          err_q      [SLOTS];
  logic [3:0]          winner_q   [SLOTS];
  logic [RX_COUNT-1:0] heard_q    [SLOTS];
  logic [RX_COUNT-1:0] ended_q    [SLOTS];
  logic [15:0]         elapsed_q  [SLOTS];
  logic [15:0]         deadline_q [SLOTS];
  logic [SLOTS-1:0]    armed_q;
  logic [63:0]         data_lo_q  [SLOTS];
  logic [31:0]         data_hi_q  [SLOTS];

  res_item_t hold_q, out_q;
  logic      hold_v_q, out_v_q;
  res_item_t last_item;

  logic [RX_IDX_W-1:0] rxi;
  logic                rx_ok;
  logic [SLOT_W-1:0]   s, sa;
  logic [SLOT_W:0]     ahead;
  logic                frame_ok, frame_end, frame_take;
  logic [RX_COUNT-1:0] rx_bit;
  logic [3:0]          len;
  logic [63:0]         mlo;
  logic [31:0]         mhi;
  logic [15:0]         end_sum;
  logic                end_expire;
  logic                rel_exp;
  logic [15:0]         rearm;
  logic                push_v;
  res_item_t           push_item;

  assign rxi   = in_q.receiver[RX_IDX_W-1:0];
  assign rx_ok = ({1'b0, in_q.receiver} < 5'(RX_COUNT));
  assign s     = in_q.seq[SLOT_W-1:0];
  assign sa    = (in_q.action == ACT_FRAME) ? s : rel_q;
  assign frame_end = in_q.seq[6];
  assign rx_bit    = RX_COUNT'(1) << rxi;

  // distance from the expected slot, modulo the ring
  always_comb begin
    if (s >= exp_q) ahead = {1'b0, s} - {1'b0, exp_q};
    else            ahead = {1'b0, s} + 6'(SLOTS) - {1'b0, exp_q};
  end

  assign frame_ok = !listening_q && rx_ok && active_q[rxi] &&
                    (in_q.stream_id == stream_q[rxi]) &&
                    ({1'b0, s} < 6'(SLOTS)) && (ahead <= MAX_AHEAD);
  assign frame_take = !frame_end && !(err_q[sa] < {2'b0, in_q.errors});

  assign len = (in_q.frame_len > 4'd12) ? 4'd12 : in_q.frame_len;

  always_comb begin
    for (int b = 0; b < 8; b++) mlo[b*8 +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
    for (int b = 0; b < 4; b++) mhi[b*8 +: 8] = (4'(b + 8) < len) ? 8'hFF : 8'h00;
  end

  assign end_sum    = sat_add(end_el_q, in_q.tick_ms);
  assign end_expire = end_run_q && (end_sum >= end_to_i);
  assign rel_exp    = armed_q[sa] && (elapsed_q[sa] >= deadline_q[sa]);
  assign rearm      = 16'(13'(period_i) * 13'd21);

  always_comb begin
    stat_o.action      = in_q.action;
    stat_o.rx_ok       = rx_ok;
    stat_o.listening   = listening_q;
    stat_o.end_expire  = end_expire;
    stat_o.init_done   = (idx_q == LAST_SLOT);
    stat_o.rel_go      = rel_exp && (k_q != SLOT_W'(SLOTS));
    stat_o.rel_endonly = (ended_q[sa] != '0) && ((heard_q[sa] & ~ended_q[sa]) == '0);
    stat_o.header_sent = header_sent_q;
  end

  always_comb begin
    push_v    = 1'b0;
    push_item = '0;
    if (cmd_i.push_hdr) begin
      push_v         = 1'b1;
      push_item.kind = KIND_HDR;
    end else if (cmd_i.rel_end || (cmd_i.tick && end_expire)) begin
      push_v         = 1'b1;
      push_item.kind = KIND_END;
    end else if (cmd_i.rel_item) begin
      push_v = 1'b1;
      if (length_q[sa] != 4'd0) begin
        push_item.kind            = KIND_VOICE;
        push_item.frame_low_res   = data_lo_q[sa];
        push_item.frame_high_res  = data_hi_q[sa];
        push_item.source_receiver = winner_q[sa];
      end else begin
        push_item.kind = KIND_SILENCE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q   <= 1'b1;
      header_sent_q <= 1'b0;
      end_run_q     <= 1'b0;
      tag_q         <= '0;
      exp_q         <= '0;
      rel_q         <= '0;
      idx_q         <= '0;
      k_q           <= '0;
      end_el_q      <= '0;
      acc_q         <= '0;
      active_q      <= '0;
      for (int i = 0; i < RX_COUNT; i++) stream_q[i] <= '0;
    end else begin
      if (cmd_i.hdr_open) begin
        tag_q         <= in_q.header_tag;
        active_q      <= rx_bit;
        for (int i = 0; i < RX_COUNT; i++)
          stream_q[i] <= (RX_IDX_W'(i) == rxi) ? in_q.stream_id : 16'h0000;
        exp_q         <= '0;
        rel_q         <= '0;
        listening_q   <= 1'b0;
        header_sent_q <= 1'b0;
        end_run_q     <= 1'b1;
        end_el_q      <= '0;
        idx_q         <= '0;
        acc_q         <= {8'b0, period_i} + {3'b0, jitter_i};
      end
      if (cmd_i.hdr_upd) begin
        active_q[rxi] <= (in_q.header_tag == tag_q);
        stream_q[rxi] <= in_q.stream_id;
      end
      if (cmd_i.init_step) begin
        idx_q <= idx_q + SLOT_W'(1);
        acc_q <= acc_q + {8'b0, period_i};
      end
      if (cmd_i.frame && frame_ok) begin
        exp_q     <= (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
        end_run_q <= 1'b1;
        end_el_q  <= '0;
        if (frame_end) active_q[rxi] <= 1'b0;
      end
      if (cmd_i.tick) begin
        k_q <= '0;
        if (end_run_q) end_el_q <= end_sum;
        if (end_expire) begin
          listening_q <= 1'b1;
          end_run_q   <= 1'b0;
        end
      end
      if (cmd_i.push_hdr) header_sent_q <= 1'b1;
      if (cmd_i.rel_end) begin
        listening_q <= 1'b1;
        end_run_q   <= 1'b0;
      end
      if (cmd_i.rel_item) begin
        rel_q <= (sa == LAST_SLOT) ? '0 : sa + SLOT_W'(1);
        k_q   <= k_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        length_q[i]   <= '0;
        err_q[i]      <= ERR_RESET;
        winner_q[i]   <= '0;
        heard_q[i]    <= '0;
        ended_q[i]    <= '0;
        elapsed_q[i]  <= '0;
        deadline_q[i] <= '0;
      end
    end else begin
      if (cmd_i.init_step) begin
        length_q[idx_q]   <= '0;
        err_q[idx_q]      <= ERR_RESET;
        winner_q[idx_q]   <= '0;
        heard_q[idx_q]    <= '0;
        ended_q[idx_q]    <= '0;
        elapsed_q[idx_q]  <= '0;
        deadline_q[idx_q] <= acc_q;
        armed_q[idx_q]    <= 1'b1;
      end
      if (cmd_i.frame && frame_ok) begin
        heard_q[sa] <= heard_q[sa] | rx_bit;
        if (frame_end) begin
          ended_q[sa] <= ended_q[sa] | rx_bit;
        end else if (frame_take) begin
          length_q[sa] <= len;
          err_q[sa]    <= {2'b0, in_q.errors};
          winner_q[sa] <= in_q.receiver;
        end
      end
      if (cmd_i.tick && !end_expire && !listening_q) begin
        for (int i = 0; i < SLOTS; i++)
          if (armed_q[i]) elapsed_q[i] <= sat_add(elapsed_q[i], in_q.tick_ms);
      end
      if (cmd_i.rel_item) begin
        length_q[sa]   <= '0;
        err_q[sa]      <= ERR_RESET;
        winner_q[sa]   <= '0;
        heard_q[sa]    <= '0;
        ended_q[sa]    <= '0;
        elapsed_q[sa]  <= '0;
        deadline_q[sa] <= rearm;
        armed_q[sa]    <= 1'b1;
      end
    end
  end

  // short frames replace only their own bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame && frame_ok && frame_take) begin
      data_lo_q[sa] <= (data_lo_q[sa] & ~mlo) | (in_q.frame_low & mlo);
      data_hi_q[sa] <= (data_hi_q[sa] & ~mhi) | (in_q.frame_high & mhi);
    end
  end

  // one result held back so the final one can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      if (push_v) begin
        hold_v_q <= 1'b1;
        out_v_q  <= hold_v_q;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
        out_v_q  <= hold_v_q;
      end
    end
  end

  always_comb begin
    last_item      = hold_q;
    last_item.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_v) begin
      hold_q <= push_item;
      out_q  <= hold_q;
    end else if (cmd_i.flush) begin
      out_q <= last_item;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

// ----- design/rvjb_chk.sv -----
module rvjb_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                res_valid_o,
  input rvjb_pkg::res_item_t res_o,
  input logic                pready
);
  import rvjb_pkg::*;

  // an accepted request always keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised after request");

  // only the final result of a request may appear once the block is idle
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !busy_o |-> res_o.last) else $error("non-final result while idle");

  // the header is always followed by another result
  a_hdr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_HDR |-> !res_o.last) else $error("header marked last");

  a_nonvoice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != KIND_VOICE |->
      res_o.frame_low_res == '0 && res_o.frame_high_res == '0 && res_o.source_receiver == '0)
    else $error("payload on non-voice result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind receiver_voting_jitter_buffer_core rvjb_chk u_chk (.*);
